FILE: rtl/line_edge_detector_top_assert.svh
// ---------------------------------------------------------------------------
// Line edge detector assertion macros
// Shared assertion forms used by the line edge detector checker.
// ---------------------------------------------------------------------------
`ifndef LINE_EDGE_DETECTOR_TOP_ASSERT_SVH
`define LINE_EDGE_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define LED_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/led_pkg.sv
// ---------------------------------------------------------------------------
// Line edge detector package
// Register indexes, reset values, field widths and default sizes.
// ---------------------------------------------------------------------------
package led_pkg;

  // Default size limits and sampling pitch.
  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int SAMPLE_STEP_DEF = 4;

  // Field and register widths.
  localparam int PIX_W   = 8;
  localparam int POS_W   = 12;
  localparam int SIZE_W  = 13;
  localparam int THR_W   = 8;
  localparam int HITS_W  = 11;
  localparam int GAP_W   = 12;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP        = 3'd4;

  // Register reset values.
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH    = 13'd1920;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT   = 13'd1080;
  localparam logic [THR_W-1:0]  RST_DIFF_THRESHOLD = 8'd30;
  localparam logic [HITS_W-1:0] RST_MIN_HITS       = 11'd10;
  localparam logic [GAP_W-1:0]  RST_MIN_GAP        = 12'd3;

  // Result orientation codes.
  localparam logic ORIENT_ROW = 1'b0;
  localparam logic ORIENT_COL = 1'b1;

endpackage

FILE: rtl/line_edge_detector_top.sv
// ---------------------------------------------------------------------------
// Line edge detector
// Finds horizontal and vertical line positions in a raster-order gray frame.
// ---------------------------------------------------------------------------
// The block takes one pixel word per cycle while in_stall is low and returns
// at most one line word per pixel, through the stage register and then the
// output register. The sustained rate is one pixel per clock while the output
// does not stall; it is set by the column count memory, which is read when a
// pixel is taken and written back from the update stage. Row decisions appear
// on the last pixel of an inner row, column decisions on the pixels of the
// last sampled row of the frame. The two memories (previous sampled row and
// per-column hit counts) need no clearing pass, so the block is ready right
// after reset. Change the registers only while the block is idle.
module line_edge_detector_top #(
  parameter int MAX_WIDTH   = led_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = led_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_STEP = led_pkg::SAMPLE_STEP_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Pixel input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [led_pkg::PIX_W-1:0]    in_pixel,
  // Line result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_orientation,
  output logic [led_pkg::POS_W-1:0]    out_edge_position,
  // Configuration write port
  input  logic                         cfg_we,
  input  logic [led_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [led_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int CIW       = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int RIW       = $clog2(MAX_HEIGHT);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int BUF_DEPTH = (MAX_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam int BIW       = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int PW        = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
  localparam int PIX_W     = led_pkg::PIX_W;
  localparam int HITS_W    = led_pkg::HITS_W;
  localparam int POS_W     = led_pkg::POS_W;

  // Work carried from the memory read cycle to the update cycle.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] left;
    logic [CIW-1:0]   x;
    logic [RIW-1:0]   y;
    logic             x_samp;
    logic             x_zero;
    logic             y_zero;
    logic             y_nz;
    logic             frame_start;
    logic             row_end;
    logic             col_act;
    logic             col_dec;
  } s1_t;

  // Configuration registers.
  logic [led_pkg::SIZE_W-1:0] frame_width_r, frame_height_r;
  logic [led_pkg::THR_W-1:0]  diff_threshold_r;
  logic [HITS_W-1:0]          min_hits_r;
  logic [led_pkg::GAP_W-1:0]  min_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= led_pkg::RST_FRAME_WIDTH;
      frame_height_r   <= led_pkg::RST_FRAME_HEIGHT;
      diff_threshold_r <= led_pkg::RST_DIFF_THRESHOLD;
      min_hits_r       <= led_pkg::RST_MIN_HITS;
      min_gap_r        <= led_pkg::RST_MIN_GAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        led_pkg::CFG_FRAME_WIDTH:    frame_width_r    <= cfg_wdata;
        led_pkg::CFG_FRAME_HEIGHT:   frame_height_r   <= cfg_wdata;
        led_pkg::CFG_DIFF_THRESHOLD: diff_threshold_r <= cfg_wdata[led_pkg::THR_W-1:0];
        led_pkg::CFG_MIN_HITS:       min_hits_r       <= cfg_wdata[HITS_W-1:0];
        led_pkg::CFG_MIN_GAP:        min_gap_r        <= cfg_wdata[led_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size clamped to the supported range.
  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    if (frame_width_r < 13'd2) begin
      w = WW'(2);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width_r);
    end
    if (frame_height_r < 13'd2) begin
      h = HW'(2);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height_r);
    end
  end

  // Handshake and pipeline control.
  logic s1_valid_r;
  s1_t  s1_r;
  logic out_valid_r;
  logic out_free;
  logic s1_go;
  logic acc;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign acc      = in_valid && !in_stall;

  // Raster position counters, with sample phase and row buffer index.
  logic [CIW-1:0] col_r, col_nxt;
  logic [RIW-1:0] row_r, row_nxt;
  logic [PW-1:0]  xph_r, xph_nxt, yph_r, yph_nxt;
  logic [BIW-1:0] idx_r, idx_nxt;
  logic [PIX_W-1:0] prev_r;

  logic           wrap_x;
  logic [CIW-1:0] x;
  logic [PW-1:0]  xph, yph, yph1;
  logic [BIW-1:0] idx;
  logic [RIW:0]   y1;
  logic [RIW-1:0] y;
  logic [CIW:0]   x_inc;
  logic [RIW:0]   y_inc;
  s1_t            s1_nxt;

  always_comb begin
    // Bring a position left past the frame size back into the frame.
    wrap_x = WW'(col_r) >= w;
    x      = wrap_x ? '0 : col_r;
    xph    = wrap_x ? '0 : xph_r;
    idx    = wrap_x ? '0 : idx_r;
    y1     = wrap_x ? {1'b0, row_r} + 1'b1 : {1'b0, row_r};
    if (wrap_x) begin
      yph1 = (yph_r == PW'(SAMPLE_STEP - 1)) ? '0 : yph_r + 1'b1;
    end else begin
      yph1 = yph_r;
    end
    if (HW'(y1) >= h) begin
      y   = '0;
      yph = '0;
    end else begin
      y   = y1[RIW-1:0];
      yph = yph1;
    end

    // Advance to the next pixel.
    x_inc = {1'b0, x} + 1'b1;
    y_inc = {1'b0, y} + 1'b1;
    if (WW'(x_inc) >= w) begin
      col_nxt = '0;
      xph_nxt = '0;
      idx_nxt = '0;
      if (HW'(y_inc) >= h) begin
        row_nxt = '0;
        yph_nxt = '0;
      end else begin
        row_nxt = y_inc[RIW-1:0];
        yph_nxt = (yph == PW'(SAMPLE_STEP - 1)) ? '0 : yph + 1'b1;
      end
    end else begin
      col_nxt = x_inc[CIW-1:0];
      row_nxt = y;
      yph_nxt = yph;
      if (xph == PW'(SAMPLE_STEP - 1)) begin
        xph_nxt = '0;
        idx_nxt = idx + 1'b1;
      end else begin
        xph_nxt = xph + 1'b1;
        idx_nxt = idx;
      end
    end

    // Per-pixel decisions that depend only on position.
    s1_nxt.pix         = in_pixel;
    s1_nxt.left        = prev_r;
    s1_nxt.x           = x;
    s1_nxt.y           = y;
    s1_nxt.x_samp      = (xph == '0);
    s1_nxt.x_zero      = (x == '0);
    s1_nxt.y_zero      = (y == '0);
    s1_nxt.y_nz        = (y != '0);
    s1_nxt.frame_start = (x == '0) && (y == '0);
    s1_nxt.row_end     = (WW'(x_inc) == w) && (y != '0) &&
                         (32'(y) + 32'd2 <= 32'(h));
    s1_nxt.col_act     = (yph == '0) && (x != '0);
    s1_nxt.col_dec     = (yph == '0) && (x != '0) &&
                         (32'(y) + 32'(SAMPLE_STEP) >= 32'(h)) &&
                         (32'(x) + 32'd2 <= 32'(w));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      xph_r  <= '0;
      yph_r  <= '0;
      idx_r  <= '0;
      prev_r <= '0;
    end else if (acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      xph_r  <= xph_nxt;
      yph_r  <= yph_nxt;
      idx_r  <= idx_nxt;
      prev_r <= in_pixel;
    end
  end

  // Sampled row buffer: read the pixel above, store this one, in one access.
  logic [PIX_W-1:0] row_buf [BUF_DEPTH];
  logic [PIX_W-1:0] above_r;

  always_ff @(posedge clk) begin
    if (acc && s1_nxt.x_samp) begin
      above_r      <= row_buf[idx];
      row_buf[idx] <= in_pixel;
    end
  end

  // Column hit counts: read on acceptance, written back from the update cycle.
  // Consecutive pixels always sit in different columns, so the write of one
  // pixel never meets the read of the next.
  logic [HITS_W-1:0] col_cnt [MAX_WIDTH];
  logic [HITS_W-1:0] cnt_rd_r;
  logic [HITS_W-1:0] col_cnt_new;

  always_ff @(posedge clk) begin
    if (acc) begin
      cnt_rd_r <= col_cnt[x];
    end
    if (s1_go && s1_r.col_act) begin
      col_cnt[s1_r.x] <= col_cnt_new;
    end
  end

  // Pipeline stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
  end

  // Line tracking state.
  logic [HITS_W-1:0] row_hits_r, row_hits_nxt;
  logic [RIW-1:0]    last_row_r, last_row_nxt;
  logic [CIW-1:0]    last_col_r, last_col_nxt;
  logic              row_seen_r, row_seen_nxt;
  logic              col_seen_r, col_seen_nxt;

  // Result of the update cycle.
  logic             res_valid;
  logic             res_orient;
  logic [POS_W-1:0] res_pos;

  logic [PIX_W-1:0] d_row, d_col;
  logic             hit_row, hit_col;
  logic             row_seen_eff, col_seen_eff;
  logic             row_line, col_line;

  always_comb begin
    // Vertical difference against the sampled row above.
    d_row   = (s1_r.pix > above_r) ? s1_r.pix - above_r : above_r - s1_r.pix;
    hit_row = s1_r.y_nz && (d_row > diff_threshold_r);
    row_hits_nxt = row_hits_r;
    if (s1_r.x_samp) begin
      if (s1_r.x_zero) begin
        row_hits_nxt = HITS_W'(hit_row);
      end else if (!(&row_hits_r)) begin
        row_hits_nxt = row_hits_r + HITS_W'(hit_row);
      end
    end

    // Horizontal difference against the left neighbor.
    d_col   = (s1_r.pix > s1_r.left) ? s1_r.pix - s1_r.left : s1_r.left - s1_r.pix;
    hit_col = d_col > diff_threshold_r;
    if (s1_r.y_zero) begin
      col_cnt_new = HITS_W'(hit_col);
    end else if (&cnt_rd_r) begin
      col_cnt_new = cnt_rd_r;
    end else begin
      col_cnt_new = cnt_rd_r + HITS_W'(hit_col);
    end

    // The seen flags start over with each frame.
    row_seen_eff = row_seen_r && !s1_r.frame_start;
    col_seen_eff = col_seen_r && !s1_r.frame_start;

    col_line = s1_r.col_dec && (col_cnt_new > min_hits_r) &&
               (!col_seen_eff ||
                ((s1_r.x > last_col_r) &&
                 (32'(s1_r.x - last_col_r) > 32'(min_gap_r))));
    row_line = s1_r.row_end && (row_hits_nxt > min_hits_r) &&
               (!row_seen_eff ||
                ((s1_r.y > last_row_r) &&
                 (32'(s1_r.y - last_row_r) > 32'(min_gap_r))));

    row_seen_nxt = row_seen_eff || row_line;
    col_seen_nxt = col_seen_eff || col_line;
    last_row_nxt = row_line ? s1_r.y : last_row_r;
    last_col_nxt = col_line ? s1_r.x : last_col_r;

    // A row decision and a column decision never fall on the same pixel.
    res_valid  = row_line || col_line;
    res_orient = row_line ? led_pkg::ORIENT_ROW : led_pkg::ORIENT_COL;
    res_pos    = row_line ? POS_W'(s1_r.y) : POS_W'(s1_r.x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_hits_r <= '0;
      last_row_r <= '0;
      last_col_r <= '0;
      row_seen_r <= 1'b0;
      col_seen_r <= 1'b0;
    end else if (s1_go) begin
      row_hits_r <= row_hits_nxt;
      last_row_r <= last_row_nxt;
      last_col_r <= last_col_nxt;
      row_seen_r <= row_seen_nxt;
      col_seen_r <= col_seen_nxt;
    end
  end

  // Output register.
  logic             out_orient_r;
  logic [POS_W-1:0] out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_orient_r <= res_orient;
      out_pos_r    <= res_pos;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_orientation   = out_orient_r;
  assign out_edge_position = out_pos_r;

endmodule

FILE: rtl/led_checker.sv
// ---------------------------------------------------------------------------
// Line edge detector checker
// Port-level checks on the line edge detector, attached by bind.
// ---------------------------------------------------------------------------
`include "line_edge_detector_top_assert.svh"

module led_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_orientation,
  input logic [led_pkg::POS_W-1:0] out_edge_position
);

  // A held result word stays put until it is taken.
  `LED_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_orientation) && $stable(out_edge_position), "result word changed while stalled")

  // The input only backs up when a result word is waiting on a stalled output.
  `LED_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")

  // Reset leaves no result word pending.
  `LED_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result word valid after reset")

endmodule

bind line_edge_detector_top led_checker u_led_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_orientation   (out_orientation),
  .out_edge_position (out_edge_position)
);

FILE: tb/sv/line_edge_checker.sv
// ---------------------------------------------------------------------------
// Line edge detector checker
// Follows the pixel words taken by the detector and predicts the line words
// that each one should produce. Every line word that leaves the block is
// compared with the oldest prediction. Mismatches are counted and passed to
// the testbench top.
// ---------------------------------------------------------------------------
module line_edge_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [led_pkg::PIX_W-1:0]     in_pixel,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_orientation,
  input  logic [led_pkg::POS_W-1:0]     out_edge_position,
  input  logic                          cfg_we,
  input  logic [led_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [led_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            lines_waiting,
  output int                            frame_left
);
  import led_pkg::*;

  localparam int unsigned STEP      = SAMPLE_STEP_DEF;
  localparam int unsigned MAX_W     = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H     = MAX_HEIGHT_DEF;
  localparam int unsigned BUF_DEPTH = (MAX_W + STEP - 1) / STEP;
  localparam int unsigned HITS_CAP  = 2047;

  typedef struct packed {
    logic             orient;
    logic [POS_W-1:0] pos;
  } line_t;

  // Register copies.
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [THR_W-1:0]  thr_reg;
  logic [HITS_W-1:0] hits_reg;
  logic [GAP_W-1:0]  gap_reg;

  // Scan position and line history.
  int unsigned col_pos;
  int unsigned row_pos;
  logic [PIX_W-1:0] left_pix;
  logic [PIX_W-1:0] row_above [BUF_DEPTH];
  int unsigned col_hits [MAX_W];
  int unsigned row_hits;
  int unsigned last_row_line;
  int unsigned last_col_line;
  bit row_seen;
  bit col_seen;

  line_t lines_due [$];
  line_t got;
  int fails;

  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned cap);
    if (v < 2) return 2;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic int unsigned add_hit(int unsigned a, int unsigned b);
    return (a + b > HITS_CAP) ? HITS_CAP : a + b;
  endfunction

  function automatic int unsigned exceeds(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return (d > thr_reg) ? 1 : 0;
  endfunction

  // Pixels still to come before the scan is back at the top left corner.
  function automatic int frame_remaining();
    int unsigned w, h, x, y;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    x = col_pos;
    y = row_pos;
    if (x >= w) begin
      x = 0;
      y++;
    end
    if (y >= h) y = 0;
    return (h - y) * w - x;
  endfunction

  // Advance the scan by one pixel and queue the line word it produces, if any.
  task automatic predict_lines(input logic [PIX_W-1:0] p);
    int unsigned w, h, x, y, last_sampled, hit, cnt, idx;
    bit found;
    line_t ln;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    x = col_pos;
    y = row_pos;
    last_sampled = ((h - 1) / STEP) * STEP;
    found = 1'b0;
    ln = '0;

    // A size change may leave the position outside the frame.
    if (x >= w) begin
      x = 0;
      y++;
    end
    if (y >= h) y = 0;
    if (x == 0 && y == 0) begin
      row_seen = 1'b0;
      col_seen = 1'b0;
    end

    // Row test: sampled columns against the same column one row up.
    if (x % STEP == 0) begin
      idx = x / STEP;
      if (idx < BUF_DEPTH) begin
        hit = (y >= 1) ? exceeds(p, row_above[idx]) : 0;
        row_hits = (x == 0) ? hit : add_hit(row_hits, hit);
        row_above[idx] = p;
      end
    end

    // Column test: sampled rows against the left neighbor.
    if (y % STEP == 0 && x >= 1 && x < MAX_W) begin
      hit = exceeds(p, left_pix);
      cnt = (y == 0) ? hit : add_hit(col_hits[x], hit);
      col_hits[x] = cnt;
      if (y == last_sampled && x <= w - 2 && cnt > hits_reg) begin
        if (!col_seen || (x > last_col_line && x - last_col_line > gap_reg)) begin
          last_col_line = x;
          col_seen = 1'b1;
          ln.orient = ORIENT_COL;
          ln.pos = x[POS_W-1:0];
          found = 1'b1;
        end
      end
    end

    // Row decision on the last pixel of an inner row.
    if (x == w - 1 && y >= 1 && y <= h - 2 && row_hits > hits_reg) begin
      if (!row_seen || (y > last_row_line && y - last_row_line > gap_reg)) begin
        last_row_line = y;
        row_seen = 1'b1;
        ln.orient = ORIENT_ROW;
        ln.pos = y[POS_W-1:0];
        found = 1'b1;
      end
    end
    if (found) lines_due.push_back(ln);

    left_pix = p;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endtask

  // Register writes, pixel tracking and line word comparison.
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      thr_reg = RST_DIFF_THRESHOLD;
      hits_reg = RST_MIN_HITS;
      gap_reg = RST_MIN_GAP;
      col_pos = 0;
      row_pos = 0;
      left_pix = '0;
      row_hits = 0;
      last_row_line = 0;
      last_col_line = 0;
      row_seen = 1'b0;
      col_seen = 1'b0;
      fails = 0;
      lines_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: width_reg = cfg_wdata[SIZE_W-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_wdata[SIZE_W-1:0];
          CFG_DIFF_THRESHOLD: thr_reg = cfg_wdata[THR_W-1:0];
          CFG_MIN_HITS: hits_reg = cfg_wdata[HITS_W-1:0];
          CFG_MIN_GAP: gap_reg = cfg_wdata[GAP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_lines(in_pixel);
      if (out_valid && !out_stall) begin
        if (lines_due.size() == 0) begin
          if (fails < 10)
            $display("unexpected line word: orientation %0d position %0d",
                     out_orientation, out_edge_position);
          fails++;
        end else begin
          got = lines_due.pop_front();
          if (got.orient !== out_orientation || got.pos !== out_edge_position) begin
            if (fails < 10)
              $display("line word mismatch: expected orientation %0d position %0d, got %0d %0d",
                       got.orient, got.pos, out_orientation, out_edge_position);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    lines_waiting <= lines_due.size();
    frame_left <= frame_remaining();
  end

endmodule

FILE: tb/sv/line_edge_detector_top_tb.sv
// ---------------------------------------------------------------------------
// Line edge detector testbench
// Feeds gray frames to the detector: a few directed frames at the edges of
// the register ranges and of the frame size, size changes in the middle of
// a frame, then random frames of lines, noise or checkers. Both channels idle
// at random. The checker beside the block predicts and compares every line
// word; this top makes the stimulus and prints the verdict.
// ---------------------------------------------------------------------------
module line_edge_detector_top_tb;
  import led_pkg::*;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_style_e;
  typedef enum int {PIX_NOISE, PIX_LINES, PIX_CHECKER} pix_style_e;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_PIXELS = 1800;
  localparam int MIN_LINES = 48;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_orientation;
  logic [POS_W-1:0]     out_edge_position;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int fail_count;
  int lines_waiting;
  int frame_left;

  // Sender and receiver pacing.
  stall_style_e stall_style = STALL_NONE;
  int stall_tick = 0;
  int stall_period = 4;
  int stall_on = 1;
  bit steady = 1'b0;
  int burst_left = 0;
  int pixels_sent = 0;
  int lines_taken = 0;
  int idle_cycles = 0;

  bit row_mark [MAX_WIDTH_DEF];
  bit col_mark [MAX_WIDTH_DEF];

  always #5 clk = ~clk;

  line_edge_detector_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_orientation   (out_orientation),
    .out_edge_position (out_edge_position),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  line_edge_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_orientation   (out_orientation),
    .out_edge_position (out_edge_position),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .lines_waiting     (lines_waiting),
    .frame_left        (frame_left)
  );

  // Receiver stall pattern.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_style)
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= ((stall_tick % stall_period) < stall_on);
      default: out_stall <= 1'b0;
    endcase
  end

  // Line word count and watchdog on cycles with no word moving.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) lines_taken <= lines_taken + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("line_edge_detector_top_tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one pixel word and hold it until it is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    if (burst_left == 0) begin
      if (!steady) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
    burst_left--;
    pixels_sent++;
  endtask

  // Stop sending and let every predicted line word come out.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (lines_waiting != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after the group.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic config_all(input int w, input int h, input int thr, input int hits,
                            input int gap);
    drain();
    put_reg(CFG_FRAME_WIDTH, w);
    put_reg(CFG_FRAME_HEIGHT, h);
    put_reg(CFG_DIFF_THRESHOLD, thr);
    put_reg(CFG_MIN_HITS, hits);
    put_reg(CFG_MIN_GAP, gap);
    cfg_we <= 1'b0;
  endtask

  // Send the first count pixels of a w by h frame in raster order.
  task automatic send_frame(input int w, input int h, input int count, input pix_style_e style);
    int x, y, n, base, amp, ink;
    logic [PIX_W-1:0] p;
    base = $urandom_range(0, 200);
    amp = $urandom_range(0, 40);
    ink = (base < 128) ? 255 - $urandom_range(0, 30) : $urandom_range(0, 30);
    for (y = 0; y < h; y++) row_mark[y] = ($urandom_range(0, 4) == 0);
    for (x = 0; x < w; x++) col_mark[x] = ($urandom_range(0, 4) == 0);
    n = 0;
    for (y = 0; y < h && n < count; y++) begin
      for (x = 0; x < w && n < count; x++) begin
        case (style)
          PIX_NOISE: p = PIX_W'($urandom_range(0, 255));
          PIX_CHECKER: p = ((x ^ y) & 1) ? 8'hFF : 8'h00;
          default: p = (row_mark[y] || col_mark[x]) ? PIX_W'(ink)
                                                     : PIX_W'(base + $urandom_range(0, amp));
        endcase
        send_pixel(p);
        n++;
      end
    end
  endtask

  // Change one register in the middle of a frame, then finish that frame.
  task automatic retune_midframe(input logic [CFG_IDX_W-1:0] idx, input int val);
    int n;
    drain();
    put_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
    n = frame_left;
    repeat (n) send_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic pick_pacing();
    steady = ($urandom_range(0, 3) == 0);
    stall_style = stall_style_e'($urandom_range(0, 2));
    stall_period = $urandom_range(2, 9);
    stall_on = $urandom_range(1, stall_period - 1);
  endtask

  initial begin
    int w, h, thr, hits, gap, sampled, pick;
    pix_style_e style;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sizes below the minimum act as two by two.
    config_all(0, 1, 0, 0, 0);
    send_frame(2, 2, 4, PIX_CHECKER);
    // Full contrast with the loosest settings gives a line everywhere allowed.
    pick_pacing();
    config_all(6, 6, 0, 0, 0);
    send_frame(6, 6, 36, PIX_CHECKER);
    // The highest threshold never counts a hit.
    config_all(5, 5, 255, 0, 0);
    send_frame(5, 5, 25, PIX_NOISE);
    // The largest gap keeps only the first line of each orientation.
    config_all(8, 9, 0, 0, 4095);
    send_frame(8, 9, 72, PIX_CHECKER);
    // Hit limits above the range.
    config_all(8, 6, 0, 2047, 0);
    send_frame(8, 6, 48, PIX_NOISE);
    config_all(8, 6, 0, 1024, 0);
    send_frame(8, 6, 48, PIX_NOISE);
    // Sizes above the maximum act as the maximum.
    pick_pacing();
    config_all(8191, 2, 0, 0, 0);
    send_frame(MAX_WIDTH_DEF, 2, 2 * MAX_WIDTH_DEF, PIX_NOISE);
    config_all(2, 5000, 0, 0, 0);
    send_frame(2, MAX_HEIGHT_DEF, 2 * MAX_HEIGHT_DEF, PIX_NOISE);
    // Width shrinks under the current column.
    config_all(12, 9, 20, 0, 1);
    send_frame(12, 9, 40, PIX_LINES);
    retune_midframe(CFG_FRAME_WIDTH, 3);
    // Height grows after the column decisions: later columns are not past them.
    config_all(8, 9, 0, 0, 0);
    send_frame(8, 9, 69, PIX_NOISE);
    retune_midframe(CFG_FRAME_HEIGHT, 13);
    // Height shrinks under the current row and restarts the frame.
    config_all(6, 10, 10, 0, 0);
    send_frame(6, 10, 30, PIX_LINES);
    retune_midframe(CFG_FRAME_HEIGHT, 4);

    // Random frames, mostly with drawn lines over a noisy background.
    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS || lines_taken < MIN_LINES) begin
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 160) : $urandom_range(2, 24);
      h = ($urandom_range(0, 15) == 0) ? $urandom_range(21, 64) : $urandom_range(2, 20);
      pick = $urandom_range(0, 7);
      thr = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(5, 100);
      sampled = ((w + 3) / 4 > (h + 3) / 4) ? (w + 3) / 4 : (h + 3) / 4;
      pick = $urandom_range(0, 15);
      hits = (pick == 0) ? 1024 : (pick == 1) ? 2047 : $urandom_range(0, sampled);
      gap = ($urandom_range(0, 15) == 0) ? 4095 : $urandom_range(0, 4);
      pick = $urandom_range(0, 5);
      style = (pick == 0) ? PIX_NOISE : (pick == 1) ? PIX_CHECKER : PIX_LINES;
      config_all(w, h, thr, hits, gap);
      pick_pacing();
      repeat ($urandom_range(1, 2)) send_frame(w, h, w * h, style);
      if ($urandom_range(0, 5) == 0) begin
        send_frame(w, h, $urandom_range(1, w * h - 1), style);
        if ($urandom_range(0, 1) == 0) retune_midframe(CFG_FRAME_WIDTH, $urandom_range(2, w));
        else retune_midframe(CFG_FRAME_HEIGHT, $urandom_range(2, 24));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("line_edge_detector_top_tb: done, clean");
    end else begin
      $display("line_edge_detector_top_tb: done, errors");
    end
    $finish;
  end

endmodule
